@@ design/eec_pkg.sv @@
// ----------------------------------------------------------------------------
// eec_pkg
// Shared codes, sideband type and exp2 coefficient functions for the
// exponential easing curve unit.
// ----------------------------------------------------------------------------
package eec_pkg;

   localparam logic [2:0] MODE_LINEAR = 3'd0;
   localparam logic [2:0] MODE_IN     = 3'd1;
   localparam logic [2:0] MODE_OUT    = 3'd2;
   localparam logic [2:0] MODE_IN_OUT = 3'd3;
   localparam logic [2:0] MODE_OUT_IN = 3'd4;

   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_START    = 2'd1;
   localparam logic [1:0] REG_CHANGE   = 2'd2;
   localparam logic [1:0] REG_DURATION = 2'd3;

   localparam logic [1:0] KIND_LIN    = 2'd0;
   localparam logic [1:0] KIND_IN     = 2'd1;
   localparam logic [1:0] KIND_OUT    = 2'd2;
   localparam logic [1:0] KIND_IN_OUT = 2'd3;

   localparam logic [1:0] POST_NONE     = 2'd0;
   localparam logic [1:0] POST_HALF     = 2'd1;
   localparam logic [1:0] POST_HALF_OFS = 2'd2;

   localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
   localparam logic [30:0] Q30_HALF = 31'h2000_0000;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] post;
      logic       zero;
      logic       full;
      logic       clamp;
      logic       low_half;
   } side_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = value;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // c_j = 2^(-2^-j) in Q30
   function automatic logic [29:0] exp_coef(input int j);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int k = 1; k <= j; k++) begin
         c = isqrt64(c << 30);
      end
      return c[29:0];
   endfunction

endpackage

@@ design/exponential_easing_curve_unit.sv @@
// Registered path: stage A, divider, exp2 chain, stage N, stage M, output.
// Throughput: one item per cycle; the divider and exp2 chain are one bit a stage.
// A stall on the result side holds the whole pipeline.
// Reset clears valid bits and loads the registers with mode linear, start 0,
// change 0, duration 1.
// ----------------------------------------------------------------------------
// exponential_easing_curve_unit
// Pipelined Penner exponential easing: start + change * curve(t/d).
// ----------------------------------------------------------------------------
module exponential_easing_curve_unit #(
   parameter int TIME_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((TIME_BITS+7)/8)*8-1:0]       req_tdata,   // elapsed_time
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,   // eased_value
   output logic [0:0]                           rsp_tuser,   // saturated
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [3:0]                           csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int TB = TIME_BITS;
   localparam int F  = FRAC_BITS;
   localparam int AW = F + 4;

   // ---------------- registers ----------------
   logic [2:0]    mode_ff;
   logic [31:0]   start_ff;
   logic [31:0]   change_ff;
   logic [TB-1:0] duration_ff;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= eec_pkg::MODE_LINEAR;
         start_ff    <= 32'd0;
         change_ff   <= 32'd0;
         duration_ff <= TB'(1);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            eec_pkg::REG_MODE:     mode_ff     <= csr_pwdata[2:0];
            eec_pkg::REG_START:    start_ff    <= csr_pwdata;
            eec_pkg::REG_CHANGE:   change_ff   <= csr_pwdata;
            eec_pkg::REG_DURATION: duration_ff <= csr_pwdata[TB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         eec_pkg::REG_MODE:     csr_prdata = {29'd0, mode_ff};
         eec_pkg::REG_START:    csr_prdata = start_ff;
         eec_pkg::REG_CHANGE:   csr_prdata = change_ff;
         eec_pkg::REG_DURATION: csr_prdata = 32'(duration_ff);
         default:               csr_prdata = 32'd0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;

   logic [TB-1:0] d_eff;
   assign d_eff = (duration_ff == '0) ? TB'(1) : duration_ff;

   // ---------------- stage A: clamp, select time ----------------
   logic               a_valid_ff;
   logic [TB-1:0]      a_te_ff, a_te_in;
   eec_pkg::side_type  a_side_ff, a_side_in;
   logic [TB-1:0]      t_raw, tc;
   logic [TB:0]        t2, t2d;

   always_comb begin
      t_raw = req_tdata[TB-1:0];
      a_side_in = '0;
      a_side_in.clamp = t_raw > d_eff;
      tc  = a_side_in.clamp ? d_eff : t_raw;
      t2  = {tc, 1'b0};
      t2d = t2 - {1'b0, d_eff};
      a_te_in = tc;
      a_side_in.post = eec_pkg::POST_NONE;
      case (mode_ff)
         eec_pkg::MODE_IN:     a_side_in.kind = eec_pkg::KIND_IN;
         eec_pkg::MODE_OUT:    a_side_in.kind = eec_pkg::KIND_OUT;
         eec_pkg::MODE_IN_OUT: a_side_in.kind = eec_pkg::KIND_IN_OUT;
         eec_pkg::MODE_OUT_IN: begin
            if (t2 < {1'b0, d_eff}) begin
               a_side_in.kind = eec_pkg::KIND_OUT;
               a_side_in.post = eec_pkg::POST_HALF;
               a_te_in        = t2[TB-1:0];
            end else begin
               a_side_in.kind = eec_pkg::KIND_IN;
               a_side_in.post = eec_pkg::POST_HALF_OFS;
               a_te_in        = t2d[TB-1:0];
            end
         end
         default:              a_side_in.kind = eec_pkg::KIND_LIN;
      endcase
      a_side_in.zero = a_te_in == '0;
      a_side_in.full = a_te_in == d_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_te_ff   <= a_te_in;
         a_side_ff <= a_side_in;
      end
   end

   // ---------------- divider: u = te * 2^F / d, one bit a stage ----------------
   logic [F:0]        div_valid_ff;
   logic [TB-1:0]     div_rem_ff  [0:F];
   logic [F:0]        div_quo_ff  [0:F];
   eec_pkg::side_type div_side_ff [0:F];

   for (genvar k = 0; k <= F; k++) begin : g_div
      logic [TB:0]       r2;
      logic [TB:0]       r2_sub;
      logic              q_bit;
      logic [F:0]        quo_prev;
      logic              valid_prev;
      eec_pkg::side_type side_prev;

      if (k == 0) begin : g_first
         assign r2         = {1'b0, a_te_ff};
         assign quo_prev   = '0;
         assign valid_prev = a_valid_ff;
         assign side_prev  = a_side_ff;
      end else begin : g_next
         assign r2         = {div_rem_ff[k-1], 1'b0};
         assign quo_prev   = div_quo_ff[k-1];
         assign valid_prev = div_valid_ff[k-1];
         assign side_prev  = div_side_ff[k-1];
      end

      assign r2_sub = r2 - {1'b0, d_eff};
      assign q_bit  = r2 >= {1'b0, d_eff};

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            div_valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_rem_ff[k]  <= q_bit ? r2_sub[TB-1:0] : r2[TB-1:0];
            div_quo_ff[k]  <= {quo_prev[F-1:0], q_bit};
            div_side_ff[k] <= side_prev;
         end
      end
   end

   // ---------------- exp2 argument and exp2 chain ----------------
   logic [F:0]        exp_valid_ff;
   logic [30:0]       exp_p_ff    [0:F];
   logic [AW-1:0]     exp_arg_ff  [0:F];
   logic [F:0]        exp_u_ff    [0:F];
   eec_pkg::side_type exp_side_ff [0:F];

   logic [F+1:0]      x_one, x_u, x_v, x_y;
   logic [AW-1:0]     x_y_ext, x_arg_in;
   eec_pkg::side_type x_side_in;

   always_comb begin
      x_one     = (F+2)'(1) << F;
      x_u       = {1'b0, div_quo_ff[F]};
      x_v       = {div_quo_ff[F], 1'b0};
      x_side_in = div_side_ff[F];
      x_side_in.low_half = x_v < x_one;
      case (x_side_in.kind)
         eec_pkg::KIND_IN:     x_y = x_one - x_u;
         eec_pkg::KIND_IN_OUT: x_y = x_side_in.low_half ? x_one - x_v : x_v - x_one;
         default:              x_y = x_u;
      endcase
      x_y_ext  = {2'b00, x_y};
      x_arg_in = (x_y_ext << 3) + (x_y_ext << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         exp_valid_ff[0] <= div_valid_ff[F];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         exp_p_ff[0]    <= eec_pkg::Q30_ONE;
         exp_arg_ff[0]  <= x_arg_in;
         exp_u_ff[0]    <= div_quo_ff[F];
         exp_side_ff[0] <= x_side_in;
      end
   end

   for (genvar j = 1; j <= F; j++) begin : g_exp
      localparam logic [29:0] COEF = eec_pkg::exp_coef(j);
      logic [60:0] mul;
      logic        use_bit;

      assign mul     = 61'(exp_p_ff[j-1]) * 61'(COEF);
      assign use_bit = exp_arg_ff[j-1][F-j];

      always_ff @(posedge clock) begin
         if (reset) begin
            exp_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            exp_valid_ff[j] <= exp_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            exp_p_ff[j]    <= use_bit ? mul[60:30] : exp_p_ff[j-1];
            exp_arg_ff[j]  <= exp_arg_ff[j-1];
            exp_u_ff[j]    <= exp_u_ff[j-1];
            exp_side_ff[j] <= exp_side_ff[j-1];
         end
      end
   end

   // ---------------- stage N: curve value g in Q30 ----------------
   logic              n_valid_ff;
   logic [30:0]       n_g_ff, n_g_in;
   logic              n_clamp_ff;
   logic [30:0]       n_e, n_c;
   eec_pkg::side_type n_side;

   always_comb begin
      n_side = exp_side_ff[F];
      n_e    = exp_p_ff[F] >> exp_arg_ff[F][AW-1:F];
      case (n_side.kind)
         eec_pkg::KIND_IN:     n_c = n_side.zero ? 31'd0 : n_e;
         eec_pkg::KIND_OUT:    n_c = n_side.full ? eec_pkg::Q30_ONE
                                                 : eec_pkg::Q30_ONE - n_e;
         eec_pkg::KIND_IN_OUT: begin
            if (n_side.zero)          n_c = 31'd0;
            else if (n_side.full)     n_c = eec_pkg::Q30_ONE;
            else if (n_side.low_half) n_c = n_e >> 1;
            else                      n_c = eec_pkg::Q30_ONE - (n_e >> 1);
         end
         default:              n_c = {exp_u_ff[F], (30-F)'(0)};
      endcase
      case (n_side.post)
         eec_pkg::POST_HALF:     n_g_in = n_c >> 1;
         eec_pkg::POST_HALF_OFS: n_g_in = eec_pkg::Q30_HALF + (n_c >> 1);
         default:                n_g_in = n_c;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (adv) begin
         n_valid_ff <= exp_valid_ff[F];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_g_ff     <= n_g_in;
         n_clamp_ff <= n_side.clamp;
      end
   end

   // ---------------- stage M: change * g ----------------
   logic               m_valid_ff;
   logic signed [63:0] m_prod_ff;
   logic               m_clamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= n_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_prod_ff  <= 64'($signed(change_ff)) * 64'($signed({1'b0, n_g_ff}));
         m_clamp_ff <= n_clamp_ff;
      end
   end

   // ---------------- output: round, add start, saturate ----------------
   logic signed [63:0] o_rnd;
   logic signed [34:0] o_sum;
   logic [31:0]        o_val;
   logic               o_sat;
   logic [31:0]        rsp_data_ff;
   logic               rsp_sat_ff;

   always_comb begin
      o_rnd = m_prod_ff + 64'sd536870912;
      o_sum = 35'($signed(start_ff)) + 35'(o_rnd >>> 30);
      if (o_sum > 35'sd2147483647) begin
         o_val = 32'h7FFF_FFFF;
         o_sat = 1'b1;
      end else if (o_sum < -35'sd2147483648) begin
         o_val = 32'h8000_0000;
         o_sat = 1'b1;
      end else begin
         o_val = o_sum[31:0];
         o_sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= o_val;
         rsp_sat_ff  <= o_sat | m_clamp_ff;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_sat_ff;

endmodule

@@ design/eec_checker.sv @@
// ----------------------------------------------------------------------------
// eec_checker
// Port-level checks on the exponential easing curve unit.
// ----------------------------------------------------------------------------
module eec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed under stall");

   // input side only stalls while a result waits
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind exponential_easing_curve_unit eec_checker u_eec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
